// ===== design/glu_pkg.sv =====
// package for the gcd/lcm unit: widths, payload structs, sequencer states
package glu_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int OPER_WIDTH = 64;
  localparam int RES_WIDTH  = 63;
  localparam int MAG_WIDTH  = DATA_WIDTH - 1;
  localparam int ADD_WIDTH  = DATA_WIDTH + 1;
  localparam int CNT_WIDTH  = $clog2(MAG_WIDTH);

  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {MAG_WIDTH{1'b0}}};
  localparam logic [MAG_WIDTH-1:0]  MAX_POS  = {MAG_WIDTH{1'b1}};

  typedef struct packed {
    logic                         opcode;
    logic signed [OPER_WIDTH-1:0] operand_a;
    logic signed [OPER_WIDTH-1:0] operand_b;
  } glu_in_t;

  typedef struct packed {
    logic [RES_WIDTH-1:0] result;
    logic                 overflow;
  } glu_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFAC,
    ST_RED,
    ST_REST,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } glu_state_e;

endpackage

// ===== design/gcd_lcm_unit.sv =====
// gcd/lcm unit: binary gcd, restoring division and shift-add multiply on one adder
//
//  beat     dir  handshake                  payload
//  input    in   in_valid_i / in_ready_o    in_data_i  (opcode, operand_a, operand_b)
//  output   out  out_valid_o / out_ready_i  out_data_o (result, overflow)
//
//  gcd: strips the k common factors of two, reduces by halving and subtracting,
//  then shifts the k twos back in; lcm then divides operand a by the gcd and
//  multiplies the quotient by operand b; subtract, divide and multiply share one
//  DATA_WIDTH+1 bit adder. a most negative operand goes straight to overflow finish.
//  in_ready_o is high only in idle; a finished beat waits in the output register,
//  so the next input is taken while out_ready_i is low.
//  rst_ni clears the sequencer and output valid; datapath registers are not reset.
module gcd_lcm_unit
  import glu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  glu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output glu_out_t out_data_o
);

  glu_state_e state_q, state_d;

  logic                 op_q, op_d;
  logic                 ovf_q, ovf_d;
  logic [MAG_WIDTH-1:0] a_q, a_d;
  logic [MAG_WIDTH-1:0] b_q, b_d;
  logic [MAG_WIDTH-1:0] u_q, u_d;
  logic [MAG_WIDTH-1:0] v_q, v_d;
  logic [MAG_WIDTH-1:0] r_q, r_d;
  logic [ADD_WIDTH-1:0] acc_q, acc_d;
  logic [CNT_WIDTH-1:0] k_q, k_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  glu_out_t             out_q, out_d;

  // input magnitudes
  logic [DATA_WIDTH-1:0] raw_a, raw_b, neg_a, neg_b;
  logic [MAG_WIDTH-1:0]  mag_a, mag_b;
  logic                  bad_in;

  // shared adder
  logic [ADD_WIDTH-1:0] add_a, add_b, add_sum;
  logic                 add_sub;
  logic                 borrow;

  always_comb begin
    raw_a  = in_data_i.operand_a[DATA_WIDTH-1:0];
    raw_b  = in_data_i.operand_b[DATA_WIDTH-1:0];
    neg_a  = ~raw_a + 1'b1;
    neg_b  = ~raw_b + 1'b1;
    mag_a  = raw_a[DATA_WIDTH-1] ? neg_a[MAG_WIDTH-1:0] : raw_a[MAG_WIDTH-1:0];
    mag_b  = raw_b[DATA_WIDTH-1] ? neg_b[MAG_WIDTH-1:0] : raw_b[MAG_WIDTH-1:0];
    bad_in = (raw_a == MOST_NEG) || (raw_b == MOST_NEG);
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_WIDTH'(add_sub);
  assign borrow  = add_sum[ADD_WIDTH-1];

  always_comb begin
    add_a = ADD_WIDTH'(u_q);
    add_b = ADD_WIDTH'(v_q);
    add_sub = 1'b1;
    unique case (state_q)
      ST_DIV: begin
        add_a   = ADD_WIDTH'({r_q, u_q[MAG_WIDTH-1]});
        add_b   = ADD_WIDTH'(v_q);
        add_sub = 1'b1;
      end
      ST_MUL: begin
        add_a   = {acc_q[ADD_WIDTH-2:0], 1'b0};
        add_b   = u_q[MAG_WIDTH-1] ? ADD_WIDTH'(b_q) : '0;
        add_sub = 1'b0;
      end
      default: begin
        add_a   = ADD_WIDTH'(u_q);
        add_b   = ADD_WIDTH'(v_q);
        add_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ovf_d       = ovf_q;
    a_d         = a_q;
    b_d         = b_q;
    u_d         = u_q;
    v_d         = v_q;
    r_d         = r_q;
    acc_d       = acc_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = (state_q == ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_data_i.opcode;
          ovf_d = bad_in;
          a_d   = mag_a;
          b_d   = mag_b;
          k_d   = '0;
          if (mag_b == '0) begin
            u_d = '0;
            v_d = mag_a;
          end else begin
            u_d = mag_a;
            v_d = mag_b;
          end
          if (bad_in) begin
            state_d = ST_FIN;
          end else if (in_data_i.opcode == OP_LCM && (mag_a == '0 || mag_b == '0)) begin
            v_d     = '0;
            state_d = ST_FIN;
          end else if (mag_a == '0 || mag_b == '0) begin
            state_d = ST_RED;
          end else begin
            state_d = ST_CFAC;
          end
        end
      end
      ST_CFAC: begin
        if (u_q[0] || v_q[0]) begin
          state_d = ST_RED;
        end else begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end
      end
      ST_RED: begin
        priority if (u_q == '0) begin
          state_d = ST_REST;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = add_sum[MAG_WIDTH-1:0];
        end
      end
      ST_REST: begin
        if (k_q != '0) begin
          v_d = v_q << 1;
          k_d = k_q - 1'b1;
        end else if (op_q == OP_GCD) begin
          state_d = ST_FIN;
        end else begin
          u_d     = a_q;
          r_d     = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (borrow) begin
          r_d = {r_q[MAG_WIDTH-2:0], u_q[MAG_WIDTH-1]};
        end else begin
          r_d = add_sum[MAG_WIDTH-1:0];
        end
        u_d   = {u_q[MAG_WIDTH-2:0], ~borrow};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_WIDTH'(MAG_WIDTH - 1)) begin
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d = add_sum;
        if (add_sum[ADD_WIDTH-1:MAG_WIDTH] != '0) begin
          ovf_d = 1'b1;
        end
        u_d   = u_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_WIDTH'(MAG_WIDTH - 1)) begin
          v_d     = add_sum[MAG_WIDTH-1:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.overflow    = ovf_q;
          out_d.result      = ovf_q ? RES_WIDTH'(MAX_POS) : RES_WIDTH'(v_q);
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    ovf_q <= ovf_d;
    a_q   <= a_d;
    b_q   <= b_d;
    u_q   <= u_d;
    v_q   <= v_d;
    r_q   <= r_d;
    acc_q <= acc_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
